FILE: hw/rtl/isan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_pkg
// Shared types and constants for the interval stream sanitizer.
// ----------------------------------------------------------------------------
package isan_pkg;

  localparam int unsigned ROW_W     = 32;
  localparam int unsigned OWNER_W   = 8;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned COUNT_BITS = 16;

  localparam logic [OWNER_W-1:0] OWNER_COUNT_RST = OWNER_W'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic signed [ROW_W-1:0] row_t;
  typedef logic [OWNER_W-1:0]      owner_t;
  typedef logic [TOTAL_W-1:0]      total_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  typedef enum logic [2:0] {
    VERDICT_KEEP         = 3'd0,
    VERDICT_INVALID      = 3'd1,
    VERDICT_INCONSISTENT = 3'd2,
    VERDICT_OVERLAP      = 3'd3,
    VERDICT_UNSORTED     = 3'd4
  } verdict_e;

  typedef struct packed {
    row_t   start_row;
    row_t   end_row;
    owner_t owner;
    logic   last;
  } rec_t;

  typedef struct packed {
    logic     keep;
    verdict_e verdict;
    row_t     start_row;
    row_t     end_row;
    owner_t   owner;
    logic     end_of_list;
    total_t   invalid_owner_total;
    total_t   inconsistent_total;
    total_t   overlapping_total;
    total_t   unsorted_total;
  } res_t;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

FILE: hw/rtl/isan_rec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_rec_if
// Valid/ready channel carrying one interval record word.
// ----------------------------------------------------------------------------
interface isan_rec_if;
  import isan_pkg::*;

  logic   valid;
  logic   ready;
  row_t   start_row;
  row_t   end_row;
  owner_t owner;
  logic   last;

  modport source (output valid, start_row, end_row, owner, last, input ready);
  modport sink   (input valid, start_row, end_row, owner, last, output ready);
endinterface

FILE: hw/rtl/isan_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_res_if
// Valid/ready channel carrying one classified record word.
// ----------------------------------------------------------------------------
interface isan_res_if;
  import isan_pkg::*;

  logic   valid;
  logic   ready;
  logic   keep;
  logic [2:0] verdict;
  row_t   out_start_row;
  row_t   out_end_row;
  owner_t out_owner;
  logic   end_of_list;
  total_t invalid_owner_total;
  total_t inconsistent_total;
  total_t overlapping_total;
  total_t unsorted_total;

  modport source (output valid, keep, verdict, out_start_row, out_end_row, out_owner,
                  end_of_list, invalid_owner_total, inconsistent_total,
                  overlapping_total, unsorted_total, input ready);
  modport sink   (input valid, keep, verdict, out_start_row, out_end_row, out_owner,
                  end_of_list, invalid_owner_total, inconsistent_total,
                  overlapping_total, unsorted_total, output ready);
endinterface

FILE: hw/rtl/isan_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_cfg_if
// Valid/ready write channel for the owner count register.
// ----------------------------------------------------------------------------
interface isan_cfg_if;
  import isan_pkg::*;

  logic   valid;
  logic   ready;
  owner_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/isan_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_in_stage
// Input register: captures one record word per cycle unless it is held full by the next stage.
// ----------------------------------------------------------------------------
module isan_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  isan_rec_if.sink      in_i,
  output logic          valid_o,
  output isan_pkg::rec_t rec_o,
  input  logic          ready_i
);
  import isan_pkg::*;

  logic valid_d, valid_q;
  rec_t rec_q;
  logic accept;

  assign in_i.ready = !valid_q || ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_q.start_row <= in_i.start_row;
      rec_q.end_row   <= in_i.end_row;
      rec_q.owner     <= in_i.owner;
      rec_q.last      <= in_i.last;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;
endmodule

FILE: hw/rtl/isan_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_classify
// Verdict logic, kept interval state, rejection counters and owner count.
// ----------------------------------------------------------------------------
module isan_classify (
  input  logic           clk_i,
  input  logic           rst_ni,
  isan_cfg_if.sink       cfg_i,
  input  isan_pkg::rec_t rec_i,
  input  logic           advance_i,
  output isan_pkg::res_t res_o
);
  import isan_pkg::*;

  owner_t   owner_count_q;
  row_t     kept_start_q, kept_start_d;
  row_t     kept_end_q, kept_end_d;
  count_t   inv_q, inv_d;
  count_t   inc_q, inc_d;
  count_t   ovl_q, ovl_d;
  count_t   uns_q, uns_d;
  verdict_e verdict;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_count_q <= OWNER_COUNT_RST;
    end else if (cfg_i.valid) begin
      owner_count_q <= cfg_i.data;
    end
  end

  always_comb begin
    priority if (rec_i.owner >= owner_count_q) begin
      verdict = VERDICT_INVALID;
    end else if (rec_i.end_row < rec_i.start_row) begin
      verdict = VERDICT_INCONSISTENT;
    end else if (rec_i.start_row <= kept_end_q) begin
      verdict = (rec_i.start_row >= kept_start_q) ? VERDICT_OVERLAP : VERDICT_UNSORTED;
    end else begin
      verdict = VERDICT_KEEP;
    end
  end

  always_comb begin
    kept_start_d = kept_start_q;
    kept_end_d   = kept_end_q;
    inv_d        = inv_q;
    inc_d        = inc_q;
    ovl_d        = ovl_q;
    uns_d        = uns_q;
    unique case (verdict)
      VERDICT_KEEP: begin
        kept_start_d = rec_i.start_row;
        kept_end_d   = rec_i.end_row;
      end
      VERDICT_INVALID:      inv_d = sat_inc(inv_q);
      VERDICT_INCONSISTENT: inc_d = sat_inc(inc_q);
      VERDICT_OVERLAP:      ovl_d = sat_inc(ovl_q);
      VERDICT_UNSORTED:     uns_d = sat_inc(uns_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_start_q <= '1;
      kept_end_q   <= '1;
      inv_q        <= '0;
      inc_q        <= '0;
      ovl_q        <= '0;
      uns_q        <= '0;
    end else if (advance_i) begin
      if (rec_i.last) begin
        kept_start_q <= '1;
        kept_end_q   <= '1;
        inv_q        <= '0;
        inc_q        <= '0;
        ovl_q        <= '0;
        uns_q        <= '0;
      end else begin
        kept_start_q <= kept_start_d;
        kept_end_q   <= kept_end_d;
        inv_q        <= inv_d;
        inc_q        <= inc_d;
        ovl_q        <= ovl_d;
        uns_q        <= uns_d;
      end
    end
  end

  always_comb begin
    res_o.keep                = (verdict == VERDICT_KEEP);
    res_o.verdict             = verdict;
    res_o.start_row           = rec_i.start_row;
    res_o.end_row             = rec_i.end_row;
    res_o.owner               = rec_i.owner;
    res_o.end_of_list         = rec_i.last;
    res_o.invalid_owner_total = TOTAL_W'(inv_d);
    res_o.inconsistent_total  = TOTAL_W'(inc_d);
    res_o.overlapping_total   = TOTAL_W'(ovl_d);
    res_o.unsorted_total      = TOTAL_W'(uns_d);
  end

`ifndef NO_ASSERTIONS
  // kept start is either the reset mark or a non-negative row
  a_kept_start_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_start_q[ROW_W-1] |-> (kept_start_q == '1))
    else $error("kept start negative but not reset mark");

  a_kept_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_end_q >= kept_start_q)
    else $error("kept end below kept start");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && rec_i.last) |=>
      (kept_start_q == '1) && (kept_end_q == '1) && (inv_q == '0) &&
      (inc_q == '0) && (ovl_q == '0) && (uns_q == '0))
    else $error("state not cleared after end of list");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(kept_start_q) && $stable(kept_end_q) && $stable(inv_q) &&
      $stable(inc_q) && $stable(ovl_q) && $stable(uns_q))
    else $error("stream state moved without a word");
`endif
endmodule

FILE: hw/rtl/isan_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isan_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module isan_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  isan_pkg::res_t res_i,
  output logic           ready_o,
  isan_res_if.source     out_o
);
  import isan_pkg::*;

  logic valid_d, valid_q;
  res_t res_q;
  logic load;

  assign ready_o = !valid_q || out_o.ready;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid               = valid_q;
  assign out_o.keep                = res_q.keep;
  assign out_o.verdict             = res_q.verdict;
  assign out_o.out_start_row       = res_q.start_row;
  assign out_o.out_end_row         = res_q.end_row;
  assign out_o.out_owner           = res_q.owner;
  assign out_o.end_of_list         = res_q.end_of_list;
  assign out_o.invalid_owner_total = res_q.invalid_owner_total;
  assign out_o.inconsistent_total  = res_q.inconsistent_total;
  assign out_o.overlapping_total   = res_q.overlapping_total;
  assign out_o.unsorted_total      = res_q.unsorted_total;
endmodule

FILE: hw/rtl/interval_stream_sanitizer_top.sv
`timescale 1ns / 1ps
// Path: a word goes through the input register and verdict logic into the result register.
// Throughput: one word per cycle; the input register and the result register each
// move on every cycle the output is taken, and verdict logic sits between them.
// Reset: asynchronous, active low; clears both stages, the kept interval, the
// counters and sets owner count to one. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// interval_stream_sanitizer_top
// Classifies interval records and keeps saturating rejection counts.
// ----------------------------------------------------------------------------
module interval_stream_sanitizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  isan_cfg_if.sink   cfg_i,
  isan_rec_if.sink   in_i,
  isan_res_if.source out_o
);
  import isan_pkg::*;

  logic s1_valid;
  rec_t s1_rec;
  logic s2_ready;
  res_t s1_res;
  logic advance;

  assign advance = s1_valid && s2_ready;

  isan_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (s1_valid),
    .rec_o   (s1_rec),
    .ready_i (s2_ready)
  );

  isan_classify u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .rec_i     (s1_rec),
    .advance_i (advance),
    .res_o     (s1_res)
  );

  isan_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .res_i   (s1_res),
    .ready_o (s2_ready),
    .out_o   (out_o)
  );
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for interval_stream_sanitizer_top. It runs short directed
// lists first. Random lists follow under four idle and stall mixes, with one
// long output hold-off. Each result word is checked field by field against
// a behavioral classifier that tracks the kept interval, the counters and the
// owner count.
// ----------------------------------------------------------------------------
module testbench;
  import isan_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PHASE_WORDS  = 230;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  logic clk_i;
  logic rst_ni;

  isan_cfg_if cfg_if ();
  isan_rec_if rec_if ();
  isan_res_if res_if ();

  interval_stream_sanitizer_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (rec_if),
    .out_o (res_if)
  );

  owner_t mdl_owner_count;
  row_t   mdl_kept_start;
  row_t   mdl_kept_end;
  count_t mdl_invalid;
  count_t mdl_inconsistent;
  count_t mdl_overlap;
  count_t mdl_unsorted;

  rec_t pending_recs[$];
  res_t expected_res[$];

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  logic        hold_go;
  logic        hold_on;
  int unsigned errors;
  int unsigned words_seen;
  int unsigned lists_seen;
  int unsigned cycles;
  int unsigned verdict_hits[5];

  function automatic count_t count_up(count_t c);
    return (c == '1) ? c : count_t'(c + 1'b1);
  endfunction

  function automatic void clear_list_state();
    mdl_kept_start   = row_t'(-1);
    mdl_kept_end     = row_t'(-1);
    mdl_invalid      = '0;
    mdl_inconsistent = '0;
    mdl_overlap      = '0;
    mdl_unsorted     = '0;
  endfunction

  function automatic res_t classify_record(rec_t r);
    res_t     res;
    verdict_e v;
    if (r.owner >= mdl_owner_count) begin
      v           = VERDICT_INVALID;
      mdl_invalid = count_up(mdl_invalid);
    end else if ($signed(r.end_row) < $signed(r.start_row)) begin
      v                = VERDICT_INCONSISTENT;
      mdl_inconsistent = count_up(mdl_inconsistent);
    end else if ($signed(r.start_row) <= $signed(mdl_kept_end)) begin
      if ($signed(r.start_row) >= $signed(mdl_kept_start)) begin
        v           = VERDICT_OVERLAP;
        mdl_overlap = count_up(mdl_overlap);
      end else begin
        v            = VERDICT_UNSORTED;
        mdl_unsorted = count_up(mdl_unsorted);
      end
    end else begin
      v              = VERDICT_KEEP;
      mdl_kept_start = r.start_row;
      mdl_kept_end   = r.end_row;
    end
    res.keep                = (v == VERDICT_KEEP);
    res.verdict             = v;
    res.start_row           = r.start_row;
    res.end_row             = r.end_row;
    res.owner               = r.owner;
    res.end_of_list         = r.last;
    res.invalid_owner_total = total_t'(mdl_invalid);
    res.inconsistent_total  = total_t'(mdl_inconsistent);
    res.overlapping_total   = total_t'(mdl_overlap);
    res.unsorted_total      = total_t'(mdl_unsorted);
    if (r.last) begin
      clear_list_state();
    end
    return res;
  endfunction

  function automatic row_t to_row(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return row_t'(v);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // driver: classify on acceptance, then offer the next word
  always @(posedge clk_i) begin
    rec_t seen_rec;
    rec_t next_rec;
    if (rst_ni) begin
      if (rec_if.valid && rec_if.ready) begin
        seen_rec.start_row = rec_if.start_row;
        seen_rec.end_row   = rec_if.end_row;
        seen_rec.owner     = rec_if.owner;
        seen_rec.last      = rec_if.last;
        expected_res.push_back(classify_record(seen_rec));
      end
      if (!rec_if.valid || rec_if.ready) begin
        if (pending_recs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          next_rec = pending_recs.pop_front();
          rec_if.valid     <= 1'b1;
          rec_if.start_row <= next_rec.start_row;
          rec_if.end_row   <= next_rec.end_row;
          rec_if.owner     <= next_rec.owner;
          rec_if.last      <= next_rec.last;
        end else begin
          rec_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        words_seen++;
        if (res_if.end_of_list) begin
          lists_seen++;
        end
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected: verdict %0d start %0h",
                   $time, res_if.verdict, res_if.out_start_row);
        end else begin
          want = expected_res.pop_front();
          if (want.verdict <= VERDICT_UNSORTED) begin
            verdict_hits[want.verdict]++;
          end
          check_field("keep", want.keep, res_if.keep);
          check_field("verdict", want.verdict, res_if.verdict);
          check_field("out_start_row", want.start_row, res_if.out_start_row);
          check_field("out_end_row", want.end_row, res_if.out_end_row);
          check_field("out_owner", want.owner, res_if.out_owner);
          check_field("end_of_list", want.end_of_list, res_if.end_of_list);
          check_field("invalid_owner_total", want.invalid_owner_total,
                      res_if.invalid_owner_total);
          check_field("inconsistent_total", want.inconsistent_total,
                      res_if.inconsistent_total);
          check_field("overlapping_total", want.overlapping_total,
                      res_if.overlapping_total);
          check_field("unsorted_total", want.unsorted_total, res_if.unsorted_total);
        end
      end
      res_if.ready <= !hold_on && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // long output hold-off while the sender keeps offering
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("interval_stream_sanitizer_top test failed");
    $finish;
  end

  task automatic push_rec(row_t s, row_t e, owner_t o, logic last);
    rec_t r;
    r.start_row = s;
    r.end_row   = e;
    r.owner     = o;
    r.last      = last;
    pending_recs.push_back(r);
  endtask

  task automatic write_owner_count(owner_t v);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    mdl_owner_count = v;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_recs.size() != 0 || rec_if.valid || expected_res.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_random_list(int unsigned len);
    longint      pos;
    longint      s;
    longint      e;
    int unsigned pick;
    owner_t      o;
    pos = ($urandom_range(9) == 0) ? 64'sh7fff_ff00 : longint'($urandom_range(2000)) - 2;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      o = (mdl_owner_count == 0) ? owner_t'($urandom)
                                 : owner_t'($urandom_range(int'(mdl_owner_count) - 1));
      if (pick < 60) begin
        s   = pos + $urandom_range(40, 1);
        e   = s + $urandom_range(60);
        pos = e;
      end else if (pick < 70) begin
        s = pos - $urandom_range(3);
        e = s + $urandom_range(20);
      end else if (pick < 78) begin
        s = pos - $urandom_range(500, 50);
        e = s + $urandom_range(10);
      end else if (pick < 84) begin
        s = pos + $urandom_range(40, 1);
        e = s - $urandom_range(1000, 1);
      end else if (pick < 91) begin
        s   = pos + $urandom_range(40, 1);
        e   = s + $urandom_range(60);
        pos = e;
        o   = owner_t'($urandom_range(255, mdl_owner_count));
      end else begin
        s = longint'($signed($urandom));
        e = longint'($signed($urandom));
        o = owner_t'($urandom);
      end
      if (pos > 64'sd2147483647) begin
        pos = 64'sd2147483647;
      end
      push_rec(to_row(s), to_row(e), o, i == len - 1);
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, owner_t oc, logic hold);
    int unsigned queued;
    int unsigned len;
    write_owner_count(oc);
    in_idle_pct   = idle;
    out_stall_pct = stall;
    queued = 0;
    while (queued < PHASE_WORDS) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 15) : $urandom_range(12, 1);
      queue_random_list(len);
      queued += len;
    end
    if (hold) begin
      hold_go = 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    rst_ni           = 1'b0;
    rec_if.valid     = 1'b0;
    rec_if.start_row = '0;
    rec_if.end_row   = '0;
    rec_if.owner     = '0;
    rec_if.last      = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    res_if.ready     = 1'b0;
    hold_go          = 1'b0;
    in_idle_pct      = 0;
    out_stall_pct    = 0;
    errors           = 0;
    words_seen       = 0;
    lists_seen       = 0;
    foreach (verdict_hits[i]) verdict_hits[i] = 0;
    mdl_owner_count = OWNER_COUNT_RST;
    clear_list_state();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // owner count at its reset value
    push_rec(0, 0, 0, 1'b0);
    push_rec(1, 1, 1, 1'b1);
    wait_drained();

    write_owner_count(4);
    push_rec(-1, 3, 0, 1'b0);
    push_rec(-2, 3, 1, 1'b0);
    push_rec(32'sh8000_0000, 32'sh7fff_ffff, 2, 1'b0);
    push_rec(0, 32'sh7fff_ffff, 3, 1'b0);
    push_rec(5, 4, 0, 1'b0);
    push_rec(32'sh7fff_ffff, 32'sh8000_0000, 0, 1'b0);
    push_rec(10, 20, 4, 1'b0);
    push_rec(10, 20, 255, 1'b0);
    push_rec(10, 20, 1, 1'b0);
    push_rec(32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1'b1);
    push_rec(0, 0, 0, 1'b0);
    push_rec(1, 1, 1, 1'b0);
    push_rec(1, 9, 2, 1'b0);
    push_rec(0, 0, 3, 1'b0);
    push_rec(2, 2, 0, 1'b1);
    wait_drained();

    write_owner_count(0);
    push_rec(5, 6, 0, 1'b0);
    push_rec(7, 8, 255, 1'b1);
    wait_drained();

    write_owner_count(255);
    push_rec(0, 10, 254, 1'b0);
    push_rec(11, 12, 255, 1'b1);
    wait_drained();

    run_phase(0, 0, 255, 1'b1);
    run_phase(59, 0, 2, 1'b0);
    run_phase(0, 59, owner_t'($urandom_range(255, 1)), 1'b0);
    run_phase(8, 8, 7, 1'b0);

    repeat (10) @(posedge clk_i);
    $display("Covered %0d result words in %0d lists over %0d cycles, several owner counts",
             words_seen, lists_seen, cycles);
    $display("Verdicts: kept %0d, invalid %0d, inconsistent %0d, overlap %0d, unsorted %0d",
             verdict_hits[VERDICT_KEEP], verdict_hits[VERDICT_INVALID],
             verdict_hits[VERDICT_INCONSISTENT], verdict_hits[VERDICT_OVERLAP],
             verdict_hits[VERDICT_UNSORTED]);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("interval_stream_sanitizer_top test passed");
    end else begin
      $display("interval_stream_sanitizer_top test failed");
    end
    $finish;
  end

endmodule

FILE: interval_stream_sanitizer_top.f
hw/rtl/isan_pkg.sv
hw/rtl/isan_rec_if.sv
hw/rtl/isan_res_if.sv
hw/rtl/isan_cfg_if.sv
hw/rtl/isan_in_stage.sv
hw/rtl/isan_classify.sv
hw/rtl/isan_out_stage.sv
hw/rtl/interval_stream_sanitizer_top.sv
tb/testbench.sv
